// ===== hdl/hrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrm_pkg: shared types and constants for the grey-level range mode block
// Beat formats, configuration register indexes, sequencer states and the
// control bundle of the best-count compare unit.
// ----------------------------------------------------------------------------
package hrm_pkg;

  localparam int PIX_W          = 8;
  localparam int BIN_COUNT      = 256;
  localparam int BIN_AW         = 8;
  localparam int SCAN_W         = 9;
  localparam int CFG_W          = 9;
  localparam int CFG_IDX_W      = 1;
  localparam int MODE_COUNT_W   = 21;
  localparam int COUNT_BITS_DEF = 21;
  localparam int COUNT_BITS_MAX = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_VALUE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_VALUE = 1'b1;

  localparam logic [CFG_W-1:0] LOW_RESET  = 9'd0;
  localparam logic [CFG_W-1:0] HIGH_RESET = 9'd256;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_pixel;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0]        mode_value;
    logic [MODE_COUNT_W-1:0] mode_count;
    logic                    found;
  } out_beat_t;

  typedef struct packed {
    logic clr;
    logic cand_vld;
  } best_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INC,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/hrm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrm_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hrm_best.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrm_best: shared compare unit of the range scan
// Holds the greatest count seen so far and its grey value; strict compare
// keeps the lowest value on a tie since the scan runs upward.
// ----------------------------------------------------------------------------
module hrm_best #(
  parameter int COUNT_BITS = hrm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire hrm_pkg::best_ctl_t          ctl,
  input  wire logic [COUNT_BITS-1:0]       cand_count,
  input  wire logic [hrm_pkg::PIX_W-1:0]   cand_value,
  output logic      [COUNT_BITS-1:0]       best_count,
  output logic      [hrm_pkg::PIX_W-1:0]   best_value
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      best_count <= '0;
      best_value <= '0;
    end else if (ctl.cand_vld && (cand_count > best_count)) begin
      best_count <= cand_count;
      best_value <= cand_value;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/histogram_range_mode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_range_mode: mode of an 8-bit grey image within a value range
// Counts pixels in 256 bins and, on the last pixel, reports the most common
// grey value in [low_value, high_value).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one pixel per beat
//   with a last_pixel mark. Each pixel is first read from its bin in the bin
//   RAM, then its saturated increment is written back through the single
//   write port; in_stall is high during the write-back.
//   On a beat marked last, the range scan runs through the one compare unit,
//   one bin per cycle, pipelined behind the RAM read; an empty range reads
//   no bin. The result then goes to the output register, and the output beat
//   (mode_value, mode_count, found) appears once it is loaded. No bin in
//   range above zero gives found = 0 and zeros.
//   The result sits in an output register; if the receiver stalls, the block
//   still accepts pixels of the next image and only waits at the end of the
//   next scan until the register is free.
//   Bins have one valid flop each, so reset and each result clear all bins
//   at once with no clearing pass. Reset also restores low_value = 0 and
//   high_value = 256. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module histogram_range_mode #(
  parameter int COUNT_BITS = hrm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire hrm_pkg::in_beat_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output hrm_pkg::out_beat_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [hrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hrm_pkg::CFG_W-1:0]     cfg_data
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers
  logic [hrm_pkg::CFG_W-1:0]  low_value;
  logic [hrm_pkg::CFG_W-1:0]  high_value;
  logic [hrm_pkg::SCAN_W-1:0] hi_eff;

  // Sequencer
  hrm_pkg::state_t state, state_next;
  logic in_accept;
  logic scan_load, scan_step, result_load;

  // Pixel held between read and write-back
  logic [hrm_pkg::PIX_W-1:0] pix_q;
  logic                      last_q;

  // Scan pointer and the compare stage, registered behind the RAM read
  logic [hrm_pkg::SCAN_W-1:0] scan_index;
  logic                       pend_vld;
  logic [hrm_pkg::BIN_AW-1:0] pend_addr;

  // Bin RAM and its per-entry valid flags
  logic [hrm_pkg::BIN_COUNT-1:0] bin_vld;
  logic                          rd_en, wr_en;
  logic [hrm_pkg::BIN_AW-1:0]    rd_addr;
  logic [COUNT_BITS-1:0]         rd_data, wr_data, cur_count;

  // Compare unit
  hrm_pkg::best_ctl_t               best_ctl;
  logic [COUNT_BITS-1:0]            cand_count, best_count;
  logic [hrm_pkg::PIX_W-1:0]        best_value;
  logic [hrm_pkg::COUNT_BITS_MAX-1:0] best_ext;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      low_value  <= hrm_pkg::LOW_RESET;
      high_value <= hrm_pkg::HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hrm_pkg::CFG_LOW_VALUE:  low_value  <= cfg_data;
        hrm_pkg::CFG_HIGH_VALUE: high_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the upper bound to the table size
  assign hi_eff = (high_value > hrm_pkg::SCAN_W'(hrm_pkg::BIN_COUNT))
                ? hrm_pkg::SCAN_W'(hrm_pkg::BIN_COUNT) : high_value;

  // --------------------------------------------------------------------------
  // Bin storage
  // --------------------------------------------------------------------------
  hrm_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (hrm_pkg::BIN_COUNT)
  ) u_bins (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pix_q),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A bin not written since the last clear reads as zero
  assign cur_count  = bin_vld[pix_q] ? rd_data : '0;
  assign wr_data    = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
  assign cand_count = bin_vld[pend_addr] ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst || result_load) begin
      bin_vld <= '0;
    end else if (wr_en) begin
      bin_vld[pix_q] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    rd_en        = 1'b0;
    rd_addr      = in_data.pixel;
    wr_en        = 1'b0;
    scan_load    = 1'b0;
    scan_step    = 1'b0;
    result_load  = 1'b0;
    best_ctl     = '0;
    unique case (state)
      hrm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          rd_en      = 1'b1;
          state_next = hrm_pkg::ST_INC;
        end
      end
      hrm_pkg::ST_INC: begin
        wr_en = 1'b1;
        if (last_q) begin
          scan_load    = 1'b1;
          best_ctl.clr = 1'b1;
          state_next   = hrm_pkg::ST_SCAN;
        end else begin
          state_next = hrm_pkg::ST_IDLE;
        end
      end
      hrm_pkg::ST_SCAN: begin
        best_ctl.cand_vld = pend_vld;
        rd_addr           = scan_index[hrm_pkg::BIN_AW-1:0];
        if (scan_index < hi_eff) begin
          rd_en     = 1'b1;
          scan_step = 1'b1;
        end else if (!pend_vld) begin
          state_next = hrm_pkg::ST_DONE;
        end
      end
      hrm_pkg::ST_DONE: begin
        // Wait for the output register to free up
        if (!out_valid || !out_stall) begin
          result_load = 1'b1;
          state_next  = hrm_pkg::ST_IDLE;
        end
      end
      default: state_next = hrm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pix_q  <= in_data.pixel;
      last_q <= in_data.last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index <= '0;
      pend_vld   <= 1'b0;
    end else begin
      pend_vld <= scan_step;
      if (scan_load) begin
        scan_index <= low_value;
      end else if (scan_step) begin
        scan_index <= scan_index + hrm_pkg::SCAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_step) begin
      pend_addr <= scan_index[hrm_pkg::BIN_AW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Compare unit
  // --------------------------------------------------------------------------
  hrm_best #(
    .COUNT_BITS (COUNT_BITS)
  ) u_best (
    .clk        (clk),
    .rst        (rst),
    .ctl        (best_ctl),
    .cand_count (cand_count),
    .cand_value (pend_addr),
    .best_count (best_count),
    .best_value (best_value)
  );

  // Fit the count to the 21-bit field: widen, then take the low bits
  assign best_ext = hrm_pkg::COUNT_BITS_MAX'(best_count);

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_data.mode_value <= best_value;
      out_data.mode_count <= best_ext[hrm_pkg::MODE_COUNT_W-1:0];
      out_data.found      <= (best_count != '0);
    end
  end

`ifndef SYNTHESIS
  // The write-back always follows its own read cycle
  a_inc_after_read: assert property (@(posedge clk) disable iff (rst)
    state == hrm_pkg::ST_INC |-> $past(state) == hrm_pkg::ST_IDLE)
    else $error("bin write-back without a preceding read");

  // Loading a result empties every bin for the next image
  a_bins_cleared: assert property (@(posedge clk) disable iff (rst)
    result_load |=> bin_vld == '0)
    else $error("bins not cleared after result");

  // A result with nothing found reports zeros
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |->
      out_data.mode_count == '0 && out_data.mode_value == '0)
    else $error("empty result carries nonzero fields");

  // The scan pointer never runs past the table
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == hrm_pkg::ST_SCAN && !scan_load && $past(state) == hrm_pkg::ST_SCAN
      |-> scan_index <= hrm_pkg::SCAN_W'(hrm_pkg::BIN_COUNT) || scan_index == $past(scan_index))
    else $error("scan pointer beyond table");

  // A compare candidate always comes from a scan read issued in the cycle before
  a_pend_from_read: assert property (@(posedge clk) disable iff (rst)
    pend_vld |-> $past(rd_en) && $past(state) == hrm_pkg::ST_SCAN)
    else $error("compare without a scan read");
`endif

endmodule
`default_nettype wire
